[rtl/core/motor_command_frame_receiver_assert.svh]
// Assertion macros for the motor command frame receiver.
// Depends on nothing; included by the top level only.
`ifndef MOTOR_COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define MOTOR_COMMAND_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCFR_ASSERT_NOW(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("mcfr assertion failed");

// Next-cycle implication, checked outside reset.
`define MCFR_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("mcfr assertion failed");

`endif

[rtl/core/mcfr_pkg.sv]
// Shared types and constants for the motor command frame receiver.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package mcfr_pkg;

  localparam int unsigned MODE_W      = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SPEED_W     = 7;
  localparam int unsigned ERR_W       = 2;
  localparam int unsigned SEL_W       = 2;
  localparam int unsigned CFG_INDEX_W = 3;

  // Link event kinds
  localparam logic [MODE_W-1:0] MODE_ADDR_GOOD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADDR_BAD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EOF       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_IGNORE    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ERROR     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DATA      = 3'd5;

  // Reply kinds and error codes
  localparam logic REPLY_STATUS = 1'b0;
  localparam logic REPLY_ERROR  = 1'b1;

  localparam logic [ERR_W-1:0] ERR_MISSING_DATA = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_DATA     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_MISSING_EOF  = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_ADDRESS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_CODE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REVERSE_CODE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COAST_CODE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STATUS_CODE  = 3'd4;

  // Slot marker, speed bound and reset values
  localparam logic [BYTE_W-1:0]  EMPTY_MARK  = 8'd150;
  localparam logic [BYTE_W-1:0]  SPEED_LIMIT = 8'd100;
  localparam logic [SPEED_W-1:0] SPEED_COAST = 7'd1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DATA = 3'b010,
    PH_EOF  = 3'b100
  } phase_t;

  typedef enum logic [SEL_W-1:0] {
    DIR_COAST = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_REV   = 2'd2
  } dir_t;

  typedef struct packed {
    logic [BYTE_W-1:0] node_address;
    logic [BYTE_W-1:0] forward_code;
    logic [BYTE_W-1:0] reverse_code;
    logic [BYTE_W-1:0] coast_code;
    logic [BYTE_W-1:0] status_code;
  } cfg_t;

  typedef struct packed {
    logic               reply_kind;
    logic [ERR_W-1:0]   error_code;
    logic [BYTE_W-1:0]  reply_address;
    logic [BYTE_W-1:0]  reply_check;
    logic [BYTE_W-1:0]  reply_direction;
    logic [SPEED_W-1:0] reply_speed;
    logic [SEL_W-1:0]   drive_select;
    logic [SPEED_W-1:0] drive_duty;
    logic               direction_switched;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/mcfr_ifs.sv]
// Valid/ready channel interfaces: link events, replies and register writes.
// Depends on mcfr_pkg.
`default_nettype none

interface mcfr_event_if;
  logic                        valid;
  logic                        ready;
  logic [mcfr_pkg::MODE_W-1:0] mode;
  logic [mcfr_pkg::BYTE_W-1:0] data_byte;
  modport source (output valid, mode, data_byte, input ready);
  modport sink (input valid, mode, data_byte, output ready);
endinterface

interface mcfr_reply_if;
  logic                         valid;
  logic                         ready;
  logic                         reply_kind;
  logic [mcfr_pkg::ERR_W-1:0]   error_code;
  logic [mcfr_pkg::BYTE_W-1:0]  reply_address;
  logic [mcfr_pkg::BYTE_W-1:0]  reply_check;
  logic [mcfr_pkg::BYTE_W-1:0]  reply_direction;
  logic [mcfr_pkg::SPEED_W-1:0] reply_speed;
  logic [mcfr_pkg::SEL_W-1:0]   drive_select;
  logic [mcfr_pkg::SPEED_W-1:0] drive_duty;
  logic                         direction_switched;
  modport source (output valid, reply_kind, error_code, reply_address, reply_check,
                  reply_direction, reply_speed, drive_select, drive_duty,
                  direction_switched, input ready);
  modport sink (input valid, reply_kind, error_code, reply_address, reply_check,
                reply_direction, reply_speed, drive_select, drive_duty,
                direction_switched, output ready);
endinterface

interface mcfr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mcfr_pkg::CFG_INDEX_W-1:0] index;
  logic [mcfr_pkg::BYTE_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/mcfr_cfg_regs.sv]
// Configuration register file: node address and the four command codes.
// Depends on mcfr_pkg.
`default_nettype none

module mcfr_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [mcfr_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [mcfr_pkg::BYTE_W-1:0]      wr_data,
  output mcfr_pkg::cfg_t                        cfg
);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_address <= 8'd1;
      cfg.forward_code <= 8'd1;
      cfg.reverse_code <= 8'd2;
      cfg.coast_code   <= 8'd0;
      cfg.status_code  <= 8'd4;
    end else if (wr_en) begin
      unique case (wr_index)
        mcfr_pkg::REG_NODE_ADDRESS: cfg.node_address <= wr_data;
        mcfr_pkg::REG_FORWARD_CODE: cfg.forward_code <= wr_data;
        mcfr_pkg::REG_REVERSE_CODE: cfg.reverse_code <= wr_data;
        mcfr_pkg::REG_COAST_CODE:   cfg.coast_code   <= wr_data;
        mcfr_pkg::REG_STATUS_CODE:  cfg.status_code  <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/mcfr_frame_engine.sv]
// Frame receive state, drive state and reply builder; one item per advance.
// Depends on mcfr_pkg.
`default_nettype none

module mcfr_frame_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic [mcfr_pkg::MODE_W-1:0] mode,
  input  wire logic [mcfr_pkg::BYTE_W-1:0] data_byte,
  input  wire mcfr_pkg::cfg_t              cfg,
  output logic                             emit,
  output mcfr_pkg::result_t                res
);

  mcfr_pkg::phase_t             phase, phase_next;
  logic [mcfr_pkg::BYTE_W-1:0]  pending_command, pending_command_next;
  logic [mcfr_pkg::BYTE_W-1:0]  pending_speed, pending_speed_next;
  logic [mcfr_pkg::BYTE_W-1:0]  pending_check, pending_check_next;
  mcfr_pkg::dir_t               drive_direction, drive_direction_next;
  logic [mcfr_pkg::SPEED_W-1:0] drive_speed, drive_speed_next;

  logic                         send_err, send_stat, switched;
  logic [mcfr_pkg::ERR_W-1:0]   err_code;
  logic                         hit_fwd, hit_rev, hit_coast, hit_status, frame_ok;
  logic [mcfr_pkg::BYTE_W-1:0]  dir_code;

  // Command decode and frame check on the collected bytes
  assign hit_fwd    = (pending_command == cfg.forward_code);
  assign hit_rev    = (pending_command == cfg.reverse_code);
  assign hit_coast  = (pending_command == cfg.coast_code);
  assign hit_status = (pending_command == cfg.status_code);
  assign frame_ok   = (pending_speed != '0) && (pending_speed < mcfr_pkg::SPEED_LIMIT) &&
                      (pending_check == (pending_command ^ pending_speed));

  // Receive sequencer
  always_comb begin
    phase_next           = phase;
    pending_command_next = pending_command;
    pending_speed_next   = pending_speed;
    pending_check_next   = pending_check;
    drive_direction_next = drive_direction;
    drive_speed_next     = drive_speed;
    send_err             = 1'b0;
    send_stat            = 1'b0;
    switched             = 1'b0;
    err_code             = mcfr_pkg::ERR_MISSING_DATA;
    unique case (phase)
      mcfr_pkg::PH_DATA: begin
        if (mode != mcfr_pkg::MODE_DATA) begin
          send_err = 1'b1;
          err_code = mcfr_pkg::ERR_MISSING_DATA;
        end else if (pending_command == mcfr_pkg::EMPTY_MARK) begin
          pending_command_next = data_byte;
        end else if (pending_speed == mcfr_pkg::EMPTY_MARK) begin
          pending_speed_next = data_byte;
        end else begin
          pending_check_next = data_byte;
          phase_next         = mcfr_pkg::PH_EOF;
        end
      end
      mcfr_pkg::PH_EOF: begin
        if (mode != mcfr_pkg::MODE_EOF) begin
          send_err = 1'b1;
          err_code = mcfr_pkg::ERR_MISSING_EOF;
        end else if (hit_fwd || hit_rev || hit_coast) begin
          if (frame_ok) begin
            // forward beats reverse, reverse beats coast
            if (hit_fwd) begin
              drive_direction_next = mcfr_pkg::DIR_FWD;
            end else if (hit_rev) begin
              drive_direction_next = mcfr_pkg::DIR_REV;
            end else begin
              drive_direction_next = mcfr_pkg::DIR_COAST;
            end
            drive_speed_next = (drive_direction_next == mcfr_pkg::DIR_COAST) ?
                               mcfr_pkg::SPEED_COAST :
                               pending_speed[mcfr_pkg::SPEED_W-1:0];
            switched  = (drive_direction_next != drive_direction);
            send_stat = 1'b1;
          end else begin
            send_err = 1'b1;
            err_code = mcfr_pkg::ERR_BAD_DATA;
          end
        end else if (hit_status) begin
          send_stat = 1'b1;
        end else begin
          send_err = 1'b1;
          err_code = mcfr_pkg::ERR_BAD_DATA;
        end
      end
      default: begin
        // idle, and any stray phase code behaves as idle
        phase_next = (mode == mcfr_pkg::MODE_ADDR_GOOD) ? mcfr_pkg::PH_DATA :
                                                          mcfr_pkg::PH_IDLE;
      end
    endcase
    // every reply empties the slots and returns to idle
    if (send_err || send_stat) begin
      phase_next           = mcfr_pkg::PH_IDLE;
      pending_command_next = mcfr_pkg::EMPTY_MARK;
      pending_speed_next   = mcfr_pkg::EMPTY_MARK;
      pending_check_next   = '0;
    end
  end

  // Reply fields, built from the drive state after this item
  always_comb begin
    unique case (drive_direction_next)
      mcfr_pkg::DIR_FWD: dir_code = cfg.forward_code;
      mcfr_pkg::DIR_REV: dir_code = cfg.reverse_code;
      default:           dir_code = cfg.coast_code;
    endcase
    emit                   = send_err || send_stat;
    res.reply_kind         = send_err ? mcfr_pkg::REPLY_ERROR : mcfr_pkg::REPLY_STATUS;
    res.error_code         = send_err ? err_code : mcfr_pkg::ERR_MISSING_DATA;
    res.reply_address      = cfg.node_address;
    res.reply_check        = send_err ? '0 : pending_check;
    res.reply_direction    = send_err ? '0 : dir_code;
    res.reply_speed        = send_err ? '0 : drive_speed_next;
    res.drive_select       = drive_direction_next;
    res.drive_duty         = (drive_direction_next == mcfr_pkg::DIR_COAST) ? '0 :
                             drive_speed_next;
    res.direction_switched = switched;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= mcfr_pkg::PH_IDLE;
      pending_command <= mcfr_pkg::EMPTY_MARK;
      pending_speed   <= mcfr_pkg::EMPTY_MARK;
      pending_check   <= '0;
      drive_direction <= mcfr_pkg::DIR_COAST;
      drive_speed     <= mcfr_pkg::SPEED_COAST;
    end else if (adv) begin
      phase           <= phase_next;
      pending_command <= pending_command_next;
      pending_speed   <= pending_speed_next;
      pending_check   <= pending_check_next;
      drive_direction <= drive_direction_next;
      drive_speed     <= drive_speed_next;
    end
  end

endmodule

`default_nettype wire

[rtl/core/motor_command_frame_receiver.sv]
// Top level of the motor command frame receiver: input register, frame
// engine, reply register and configuration registers. Depends on mcfr_pkg,
// the channel interfaces in mcfr_ifs.sv and the assertion macro header.
//
//   channel   role    payload
//   events    sink    mode, data_byte
//   replies   source  reply_kind .. direction_switched (nine fields)
//   cfg       sink    index, data (register write, always ready)
//
// One item per cycle while the reply register is not stalled. An accepted item
// is held in the input register, is decoded against the frame state and, if it
// ends a frame, lands in the reply register, which drives reply valid.
// Synchronous active-high reset clears the frame and drive state and loads
// the register defaults. A stalled reply holds the engine; the input register
// keeps taking items while it is free or draining.
`default_nettype none
`include "motor_command_frame_receiver_assert.svh"

module motor_command_frame_receiver (
  input wire logic     clk,
  input wire logic     rst,
  mcfr_event_if.sink   events,
  mcfr_reply_if.source replies,
  mcfr_cfg_if.sink     cfg
);

  logic                        inq_valid;
  logic [mcfr_pkg::MODE_W-1:0] inq_mode;
  logic [mcfr_pkg::BYTE_W-1:0] inq_byte;
  logic                        res_valid;
  mcfr_pkg::result_t           res_q;
  mcfr_pkg::result_t           res;
  logic                        emit;
  logic                        adv;
  mcfr_pkg::cfg_t              cfg_q;

  // Engine advances when the reply register can take whatever it produces
  assign adv          = inq_valid && (!res_valid || replies.ready);
  assign events.ready = !inq_valid || adv;
  assign cfg.ready    = 1'b1;

  mcfr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid && cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  mcfr_frame_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .mode      (inq_mode),
    .data_byte (inq_byte),
    .cfg       (cfg_q),
    .emit      (emit),
    .res       (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (events.ready) begin
      inq_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      inq_mode <= events.mode;
      inq_byte <= events.data_byte;
    end
  end

  // Reply register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= emit;
    end else if (replies.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      res_q <= res;
    end
  end

  assign replies.valid              = res_valid;
  assign replies.reply_kind         = res_q.reply_kind;
  assign replies.error_code         = res_q.error_code;
  assign replies.reply_address      = res_q.reply_address;
  assign replies.reply_check        = res_q.reply_check;
  assign replies.reply_direction    = res_q.reply_direction;
  assign replies.reply_speed        = res_q.reply_speed;
  assign replies.drive_select       = res_q.drive_select;
  assign replies.drive_duty         = res_q.drive_duty;
  assign replies.direction_switched = res_q.direction_switched;

  // Checks
  `MCFR_ASSERT_NOW(a_error_fields, clk, rst,
    replies.valid && (replies.reply_kind == mcfr_pkg::REPLY_ERROR),
    (replies.reply_check == '0) && (replies.reply_speed == '0) &&
    !replies.direction_switched)
  `MCFR_ASSERT_NOW(a_coast_no_duty, clk, rst,
    replies.valid && (replies.drive_select == mcfr_pkg::DIR_COAST),
    replies.drive_duty == '0)
  `MCFR_ASSERT_NOW(a_status_code, clk, rst,
    replies.valid && (replies.reply_kind == mcfr_pkg::REPLY_STATUS),
    (replies.error_code == mcfr_pkg::ERR_MISSING_DATA) && (replies.reply_speed != '0))
  `MCFR_ASSERT_NEXT(a_stall_holds_item, clk, rst,
    inq_valid && !adv,
    inq_valid && $stable(inq_mode) && $stable(inq_byte))

endmodule

`default_nettype wire

[dv/motor_command_frame_receiver_test.sv]
`timescale 1ns / 1ps
// Testbench for motor_command_frame_receiver: directed and random link events, with a
// behavioral predictor that checks every reply frame field by field.
// Depends on mcfr_pkg and the channel interfaces in mcfr_ifs.sv.
module motor_command_frame_receiver_test;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TIMEOUT_NS = 10_000_000;
  localparam logic [mcfr_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [mcfr_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcfr_event_if ev ();
  mcfr_reply_if rep ();
  mcfr_cfg_if cf ();

  motor_command_frame_receiver u_top (
    .clk(clk),
    .rst(rst),
    .events(ev),
    .replies(rep),
    .cfg(cf)
  );

  // Predictor state
  mcfr_pkg::cfg_t regs_model;
  mcfr_pkg::phase_t rx_phase;
  logic [mcfr_pkg::BYTE_W-1:0] slot_command;
  logic [mcfr_pkg::BYTE_W-1:0] slot_speed;
  logic [mcfr_pkg::BYTE_W-1:0] slot_check;
  mcfr_pkg::dir_t drive_dir;
  logic [mcfr_pkg::SPEED_W-1:0] drive_spd;
  mcfr_pkg::result_t expected_replies[$];

  int unsigned fail_count = 0;
  bit idling_on = 1'b0;
  int unsigned stall_left = 0;

  always #5 clk = ~clk;

  // Gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_slots();
    slot_command = mcfr_pkg::EMPTY_MARK;
    slot_speed   = mcfr_pkg::EMPTY_MARK;
    slot_check   = '0;
    rx_phase     = mcfr_pkg::PH_IDLE;
  endfunction

  // Build one reply from the current drive, queue it and end the frame
  function automatic void push_reply(logic kind, logic [mcfr_pkg::ERR_W-1:0] code,
                                     bit switched);
    mcfr_pkg::result_t r;
    r = '0;
    r.reply_kind    = kind;
    r.reply_address = regs_model.node_address;
    r.drive_select  = drive_dir;
    r.drive_duty    = (drive_dir == mcfr_pkg::DIR_COAST) ? '0 : drive_spd;
    if (kind == mcfr_pkg::REPLY_ERROR) begin
      r.error_code = code;
    end else begin
      r.reply_check = slot_check;
      if (drive_dir == mcfr_pkg::DIR_FWD) r.reply_direction = regs_model.forward_code;
      else if (drive_dir == mcfr_pkg::DIR_REV) r.reply_direction = regs_model.reverse_code;
      else r.reply_direction = regs_model.coast_code;
      r.reply_speed        = drive_spd;
      r.direction_switched = switched;
    end
    expected_replies.push_back(r);
    clear_slots();
  endfunction

  // End of frame: decode the command, validate, update the drive
  function automatic void close_frame();
    mcfr_pkg::dir_t target;
    bit switched;
    if (slot_command == regs_model.forward_code) target = mcfr_pkg::DIR_FWD;
    else if (slot_command == regs_model.reverse_code) target = mcfr_pkg::DIR_REV;
    else if (slot_command == regs_model.coast_code) target = mcfr_pkg::DIR_COAST;
    else if (slot_command == regs_model.status_code) begin
      push_reply(mcfr_pkg::REPLY_STATUS, mcfr_pkg::ERR_MISSING_DATA, 1'b0);
      return;
    end else begin
      push_reply(mcfr_pkg::REPLY_ERROR, mcfr_pkg::ERR_BAD_DATA, 1'b0);
      return;
    end
    if (slot_speed == '0 || slot_speed >= mcfr_pkg::SPEED_LIMIT ||
        slot_check != (slot_command ^ slot_speed)) begin
      push_reply(mcfr_pkg::REPLY_ERROR, mcfr_pkg::ERR_BAD_DATA, 1'b0);
      return;
    end
    switched  = (drive_dir != target);
    drive_dir = target;
    drive_spd = (target == mcfr_pkg::DIR_COAST) ? mcfr_pkg::SPEED_COAST :
                slot_speed[mcfr_pkg::SPEED_W-1:0];
    push_reply(mcfr_pkg::REPLY_STATUS, mcfr_pkg::ERR_MISSING_DATA, switched);
  endfunction

  function automatic void predict_event(logic [mcfr_pkg::MODE_W-1:0] m,
                                        logic [mcfr_pkg::BYTE_W-1:0] b);
    case (rx_phase)
      mcfr_pkg::PH_DATA: begin
        if (m != mcfr_pkg::MODE_DATA) begin
          push_reply(mcfr_pkg::REPLY_ERROR, mcfr_pkg::ERR_MISSING_DATA, 1'b0);
        end else if (slot_command == mcfr_pkg::EMPTY_MARK) slot_command = b;
        else if (slot_speed == mcfr_pkg::EMPTY_MARK) slot_speed = b;
        else begin
          slot_check = b;
          rx_phase   = mcfr_pkg::PH_EOF;
        end
      end
      mcfr_pkg::PH_EOF: begin
        if (m == mcfr_pkg::MODE_EOF) close_frame();
        else push_reply(mcfr_pkg::REPLY_ERROR, mcfr_pkg::ERR_MISSING_EOF, 1'b0);
      end
      default: begin
        rx_phase = (m == mcfr_pkg::MODE_ADDR_GOOD) ? mcfr_pkg::PH_DATA : mcfr_pkg::PH_IDLE;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Reply checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void check_reply();
    mcfr_pkg::result_t want;
    if (expected_replies.size() == 0) begin
      $error("reply with none expected: reply_kind %0d, error_code %0d",
             rep.reply_kind, rep.error_code);
      fail_count++;
      return;
    end
    want = expected_replies.pop_front();
    check_field("reply_kind", 8'(want.reply_kind), 8'(rep.reply_kind));
    check_field("error_code", 8'(want.error_code), 8'(rep.error_code));
    check_field("reply_address", want.reply_address, rep.reply_address);
    check_field("reply_check", want.reply_check, rep.reply_check);
    check_field("reply_direction", want.reply_direction, rep.reply_direction);
    check_field("reply_speed", 8'(want.reply_speed), 8'(rep.reply_speed));
    check_field("drive_select", 8'(want.drive_select), 8'(rep.drive_select));
    check_field("drive_duty", 8'(want.drive_duty), 8'(rep.drive_duty));
    check_field("direction_switched", 8'(want.direction_switched),
                8'(rep.direction_switched));
  endfunction

  // Monitor: replies, register writes and accepted items, all sampled at the edge
  always @(posedge clk) begin
    if (rst) begin
      regs_model = '{8'd1, 8'd1, 8'd2, 8'd0, 8'd4};
      drive_dir  = mcfr_pkg::DIR_COAST;
      drive_spd  = mcfr_pkg::SPEED_COAST;
      clear_slots();
    end else begin
      if (rep.valid && rep.ready) check_reply();
      if (cf.valid && cf.ready) begin
        case (cf.index)
          mcfr_pkg::REG_NODE_ADDRESS: regs_model.node_address = cf.data;
          mcfr_pkg::REG_FORWARD_CODE: regs_model.forward_code = cf.data;
          mcfr_pkg::REG_REVERSE_CODE: regs_model.reverse_code = cf.data;
          mcfr_pkg::REG_COAST_CODE:   regs_model.coast_code   = cf.data;
          mcfr_pkg::REG_STATUS_CODE:  regs_model.status_code  = cf.data;
          default: ;
        endcase
      end
      if (ev.valid && ev.ready) predict_event(ev.mode, ev.data_byte);
    end
  end

  // Reply backpressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) rep.ready <= 1'b1;
    end else if (idling_on && $urandom_range(0, 99) < 25) begin
      rep.ready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      rep.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one item; valid stays high afterwards so back-to-back items need no gap
  task automatic send_event(logic [mcfr_pkg::MODE_W-1:0] m, logic [mcfr_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 99) < 30) begin
      gap = pick_gap();
      ev.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev.valid     <= 1'b1;
    ev.mode      <= m;
    ev.data_byte <= b;
    @(posedge clk);
    while (!ev.ready) @(posedge clk);
  endtask

  task automatic hold_until_replied();
    ev.valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  // Wait out all replies, then make sure the receiver is back in idle
  task automatic drain_block();
    hold_until_replied();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (rx_phase != mcfr_pkg::PH_IDLE) begin
      send_event(mcfr_pkg::MODE_ERROR, '0);
      hold_until_replied();
      repeat (SETTLE_CYCLES) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [mcfr_pkg::CFG_INDEX_W-1:0] idx,
                           logic [mcfr_pkg::BYTE_W-1:0] value);
    cf.valid <= 1'b1;
    cf.index <= idx;
    cf.data  <= value;
    @(posedge clk);
    while (!cf.ready) @(posedge clk);
  endtask

  // Only called with the receiver idle
  task automatic set_config(mcfr_pkg::cfg_t c);
    write_reg(mcfr_pkg::REG_NODE_ADDRESS, c.node_address);
    write_reg(mcfr_pkg::REG_FORWARD_CODE, c.forward_code);
    write_reg(mcfr_pkg::REG_REVERSE_CODE, c.reverse_code);
    write_reg(mcfr_pkg::REG_COAST_CODE, c.coast_code);
    write_reg(mcfr_pkg::REG_STATUS_CODE, c.status_code);
    cf.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame_bytes(logic [mcfr_pkg::BYTE_W-1:0] cmd,
                                  logic [mcfr_pkg::BYTE_W-1:0] spd,
                                  logic [mcfr_pkg::BYTE_W-1:0] chk,
                                  logic [mcfr_pkg::MODE_W-1:0] tail);
    send_event(mcfr_pkg::MODE_ADDR_GOOD, 8'h00);
    send_event(mcfr_pkg::MODE_DATA, cmd);
    send_event(mcfr_pkg::MODE_DATA, spd);
    send_event(mcfr_pkg::MODE_DATA, chk);
    send_event(tail, 8'hFF);
  endtask

  // Random frame, mostly well formed; returns the number of items sent
  task automatic send_frame(output int unsigned n_sent);
    logic [mcfr_pkg::BYTE_W-1:0] cmd, spd, chk;
    logic [mcfr_pkg::MODE_W-1:0] m;
    int unsigned pick, cut;
    pick = $urandom_range(0, 99);
    if (pick < 25) cmd = regs_model.forward_code;
    else if (pick < 45) cmd = regs_model.reverse_code;
    else if (pick < 60) cmd = regs_model.coast_code;
    else if (pick < 72) cmd = regs_model.status_code;
    else cmd = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 75) spd = 8'($urandom_range(1, 99));
    else if (pick < 80) spd = 8'd1;
    else if (pick < 85) spd = 8'd99;
    else if (pick < 89) spd = 8'd0;
    else if (pick < 93) spd = mcfr_pkg::SPEED_LIMIT;
    else if (pick < 95) spd = mcfr_pkg::EMPTY_MARK;
    else spd = 8'($urandom_range(0, 255));
    chk = ($urandom_range(0, 99) < 85) ? (cmd ^ spd) : 8'($urandom_range(0, 255));

    send_event(mcfr_pkg::MODE_ADDR_GOOD, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 6) begin
      // frame broken off by a control event
      cut = $urandom_range(0, 2);
      if (cut > 0) send_event(mcfr_pkg::MODE_DATA, cmd);
      if (cut > 1) send_event(mcfr_pkg::MODE_DATA, spd);
      do m = mcfr_pkg::MODE_W'($urandom); while (m == mcfr_pkg::MODE_DATA);
      send_event(m, 8'($urandom_range(0, 255)));
      n_sent = cut + 2;
    end else begin
      send_event(mcfr_pkg::MODE_DATA, cmd);
      send_event(mcfr_pkg::MODE_DATA, spd);
      send_event(mcfr_pkg::MODE_DATA, chk);
      if ($urandom_range(0, 99) < 90) m = mcfr_pkg::MODE_EOF;
      else do m = mcfr_pkg::MODE_W'($urandom); while (m == mcfr_pkg::MODE_EOF);
      send_event(m, 8'($urandom_range(0, 255)));
      n_sent = 5;
    end
  endtask

  task automatic run_random(int unsigned n_items, bit idle_en);
    int unsigned done, k, noise;
    logic [mcfr_pkg::MODE_W-1:0] m;
    done = 0;
    idling_on = idle_en;
    while (done < n_items) begin
      // idle-phase noise, ignored by the block
      if ($urandom_range(0, 99) < 12) begin
        noise = $urandom_range(1, 3);
        repeat (noise) begin
          do m = mcfr_pkg::MODE_W'($urandom); while (m == mcfr_pkg::MODE_ADDR_GOOD);
          send_event(m, 8'($urandom_range(0, 255)));
        end
      end
      send_frame(k);
      done += k;
      if ($urandom_range(0, 99) < 2) hold_until_replied();
      if (idle_en && $urandom_range(0, 99) < 4) idling_on = !idling_on;
    end
    drain_block();
    idling_on = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_idle_events();
    send_event(mcfr_pkg::MODE_ADDR_BAD, 8'hFF);
    send_event(mcfr_pkg::MODE_IGNORE, 8'h00);
    send_event(mcfr_pkg::MODE_ERROR, 8'hA5);
    send_event(MODE_SPARE_LO, 8'hC3);
    send_event(MODE_SPARE_HI, 8'h5A);
    drain_block();
  endtask

  task automatic test_valid_frames();
    // forward at full speed
    send_frame_bytes(regs_model.forward_code, 8'd99, regs_model.forward_code ^ 8'd99,
                     mcfr_pkg::MODE_EOF);
    // empty marker re-opens the slot: reverse at speed 1
    send_event(mcfr_pkg::MODE_ADDR_GOOD, 8'hFF);
    send_event(mcfr_pkg::MODE_DATA, mcfr_pkg::EMPTY_MARK);
    send_event(mcfr_pkg::MODE_DATA, regs_model.reverse_code);
    send_event(mcfr_pkg::MODE_DATA, mcfr_pkg::EMPTY_MARK);
    send_event(mcfr_pkg::MODE_DATA, 8'd1);
    send_event(mcfr_pkg::MODE_DATA, regs_model.reverse_code ^ 8'd1);
    send_event(mcfr_pkg::MODE_EOF, 8'h00);
    // status request skips the check
    send_frame_bytes(regs_model.status_code, 8'd0, 8'hFF, mcfr_pkg::MODE_EOF);
    drain_block();
  endtask

  task automatic test_error_frames();
    // control event in the middle of data
    send_event(mcfr_pkg::MODE_ADDR_GOOD, 8'h00);
    send_event(mcfr_pkg::MODE_DATA, regs_model.forward_code);
    send_event(mcfr_pkg::MODE_ADDR_GOOD, 8'h00);
    // anything but end of frame after the check byte
    send_frame_bytes(regs_model.coast_code, 8'd10, regs_model.coast_code ^ 8'd10,
                     mcfr_pkg::MODE_DATA);
    drain_block();
  endtask

  task automatic test_default_traffic();
    run_random(150, 1'b0);
    run_random(150, 1'b1);
  endtask

  task automatic test_register_extremes();
    set_config('{8'hFF, 8'hFF, 8'h00, mcfr_pkg::EMPTY_MARK, 8'h80});
    run_random(300, 1'b1);
  endtask

  task automatic test_overlapping_codes();
    // all equal: forward wins
    set_config('{8'h00, 8'h07, 8'h07, 8'h07, 8'h07});
    send_frame_bytes(8'h07, 8'd20, 8'h07 ^ 8'd20, mcfr_pkg::MODE_EOF);
    run_random(200, 1'b1);
    // coast shares its code with status: coast wins
    set_config('{8'h55, 8'h10, 8'h20, 8'h30, 8'h30});
    send_frame_bytes(8'h30, 8'd5, 8'h30 ^ 8'd5, mcfr_pkg::MODE_EOF);
    run_random(200, 1'b1);
  endtask

  task automatic test_random_registers();
    mcfr_pkg::cfg_t c;
    repeat (3) begin
      c.node_address = 8'($urandom_range(0, 255));
      c.forward_code = 8'($urandom_range(0, 255));
      c.reverse_code = 8'($urandom_range(0, 255));
      c.coast_code   = 8'($urandom_range(0, 255));
      c.status_code  = 8'($urandom_range(0, 255));
      set_config(c);
      run_random(250, 1'b1);
    end
  endtask

  // Main sequence
  initial begin
    ev.valid     = 1'b0;
    ev.mode      = mcfr_pkg::MODE_IGNORE;
    ev.data_byte = '0;
    cf.valid     = 1'b0;
    cf.index     = mcfr_pkg::REG_NODE_ADDRESS;
    cf.data      = '0;
    rep.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_events();
    test_valid_frames();
    test_error_frames();
    test_default_traffic();
    test_register_extremes();
    test_overlapping_codes();
    test_random_registers();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule
